### hw/rtl/tch_pkg.sv
// shared types, constants and codes of the tls client hello parser
package tch_pkg;

    localparam int DEF_LENGTH_BITS = 16;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0]  RECORD_HANDSHAKE = 8'h16;
    localparam logic [7:0]  MSG_CLIENT_HELLO = 8'h01;
    localparam logic [15:0] EXT_SERVER_NAME  = 16'h0000;
    localparam logic [15:0] EXT_ALPN         = 16'h0010;
    localparam logic [15:0] EXT_SUPP_VERS    = 16'h002B;
    localparam int          MIN_HELLO_BYTES  = 44;
    localparam int          HS_HEADER_BYTES  = 9;

    // offsets in the fixed part of the hello
    localparam int FX_REC_TYPE   = 0;
    localparam int FX_REC_VER_HI = 1;
    localparam int FX_REC_VER_LO = 2;
    localparam int FX_REC_LEN_HI = 3;
    localparam int FX_REC_LEN_LO = 4;
    localparam int FX_MSG_TYPE   = 5;
    localparam int FX_MSG_LEN_0  = 6;
    localparam int FX_MSG_LEN_1  = 7;
    localparam int FX_MSG_LEN_2  = 8;
    localparam int FX_LEG_VER_HI = 9;
    localparam int FX_LEG_VER_LO = 10;
    localparam int FX_SESSION    = 43;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_FIXED      = 4'd1,
        PH_CIPHER_LEN = 4'd2,
        PH_CIPHERS    = 4'd3,
        PH_EXTS_LEN   = 4'd4,
        PH_EXT_HDR    = 4'd5,
        PH_SNI_LIST   = 4'd6,
        PH_SNI_ENTRY  = 4'd7,
        PH_SNI_NAME   = 4'd8,
        PH_ALPN_LIST  = 4'd9,
        PH_ALPN_LEN   = 4'd10,
        PH_ALPN_NAME  = 4'd11,
        PH_SV_LIST    = 4'd12,
        PH_SV_PAIR    = 4'd13,
        PH_SKIP       = 4'd14,
        PH_DONE       = 4'd15
    } phase_t;

    localparam logic [3:0] EV_RECORD_VER = 4'd0;
    localparam logic [3:0] EV_LEGACY_VER = 4'd1;
    localparam logic [3:0] EV_CIPHER     = 4'd2;
    localparam logic [3:0] EV_EXTENSION  = 4'd3;
    localparam logic [3:0] EV_SNI_BYTE   = 4'd4;
    localparam logic [3:0] EV_ALPN_START = 4'd5;
    localparam logic [3:0] EV_ALPN_BYTE  = 4'd6;
    localparam logic [3:0] EV_SUPP_VER   = 4'd7;
    localparam logic [3:0] EV_ACCEPT     = 4'd8;
    localparam logic [3:0] EV_REJECT     = 4'd9;

    typedef struct packed {
        logic        start_of_message;
        logic [7:0]  data_byte;
        logic [15:0] message_length;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  event_kind;
        logic [23:0] value;
        logic [16:0] record_bytes;
        logic        last_of_message;
    } out_word_t;

    // words written to the result queue in one cycle, second only with first
    typedef struct packed {
        logic      v0;
        out_word_t w0;
        logic      v1;
        out_word_t w1;
    } push_t;

endpackage

### hw/rtl/tch_queue.sv
// result queue taking up to two words a cycle and giving one while m_ready is high
module tch_queue #(
    parameter int DEPTH = tch_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  tch_pkg::push_t     push,
    output logic               room,
    output logic               m_valid,
    input  logic               m_ready,
    output tch_pkg::out_word_t m_word
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tch_pkg::out_word_t store_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next, rptr_reg, rptr_next, wptr_1;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
        inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign pop     = m_valid & m_ready;
    assign m_valid = (count_reg != '0);
    assign m_word  = store_reg[rptr_reg];
    assign room    = (count_reg <= CNT_W'(DEPTH - 2));
    assign wptr_1  = inc(wptr_reg);

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = pop ? inc(rptr_reg) : rptr_reg;
        count_next = count_reg - CNT_W'(pop);
        if (push.v0 && push.v1) begin
            wptr_next  = inc(wptr_1);
            count_next = count_next + CNT_W'(2);
        end else if (push.v0) begin
            wptr_next  = wptr_1;
            count_next = count_next + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.v0) begin
            store_reg[wptr_reg] <= push.w0;
        end
        if (push.v0 && push.v1) begin
            store_reg[wptr_1] <= push.w1;
        end
    end

endmodule

### hw/rtl/tch_core.sv
// byte parser state and event generation for one client hello
module tch_core #(
    parameter int LENGTH_BITS = tch_pkg::DEF_LENGTH_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  tch_pkg::in_word_t word,
    output tch_pkg::push_t    push
);
    localparam int PW = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 2;
    localparam int HW = 25;

    tch_pkg::phase_t        phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] off_reg, off_next, tl_reg, tl_next;
    logic [15:0]            rl_reg, rl_next, ir_reg, ir_next, ce_reg, ce_next;
    logic [23:0]            hl_reg, hl_next;
    logic [PW-1:0]          ee_reg, ee_next, xe_reg, xe_next, le_reg, le_next;
    logic [7:0]             hb_reg, hb_next;
    logic                   rej_reg, rej_next, nt_reg, nt_next;

    always_comb begin
        tch_pkg::phase_t ph0;
        logic [PW-1:0]   off, pos, v, tl, lim;
        logic [7:0]      b;
        logic [15:0]     b16;
        logic            body, dv;
        tch_pkg::out_word_t dw, fw;

        phase_next = phase_reg;
        off_next   = off_reg;
        tl_next    = tl_reg;
        rl_next    = rl_reg;
        hl_next    = hl_reg;
        ee_next    = ee_reg;
        xe_next    = xe_reg;
        le_next    = le_reg;
        ir_next    = ir_reg;
        ce_next    = ce_reg;
        hb_next    = hb_reg;
        rej_next   = rej_reg;
        nt_next    = nt_reg;
        dv         = 1'b0;
        dw         = '0;
        fw         = '0;
        push       = '0;
        b          = word.data_byte;
        pos        = '0;
        v          = '0;
        lim        = '0;

        if (accept && word.start_of_message) begin
            phase_next = tch_pkg::PH_FIXED;
            off_next   = '0;
            tl_next    = LENGTH_BITS'(PW'(word.message_length));
            rl_next    = '0;
            hl_next    = '0;
            ee_next    = '0;
            xe_next    = '0;
            le_next    = '0;
            ir_next    = '0;
            ce_next    = '0;
            hb_next    = '0;
            rej_next   = 1'b0;
            nt_next    = 1'b0;
        end
        ph0  = phase_next;
        off  = PW'(off_next);
        tl   = PW'(tl_next);
        b16  = {hb_next, b};
        body = (ph0 >= tch_pkg::PH_SNI_LIST) && (ph0 <= tch_pkg::PH_SKIP);

        if (accept && ph0 != tch_pkg::PH_IDLE) begin
            case (ph0)
                tch_pkg::PH_FIXED: begin
                    case (off)
                        PW'(tch_pkg::FX_REC_TYPE): begin
                            if (b != tch_pkg::RECORD_HANDSHAKE ||
                                tl < PW'(tch_pkg::MIN_HELLO_BYTES)) begin
                                rej_next = 1'b1; phase_next = tch_pkg::PH_DONE;
                            end
                        end
                        PW'(tch_pkg::FX_REC_VER_HI), PW'(tch_pkg::FX_REC_LEN_HI),
                        PW'(tch_pkg::FX_LEG_VER_HI): hb_next = b;
                        PW'(tch_pkg::FX_REC_VER_LO): begin
                            dv = 1'b1; dw.event_kind = tch_pkg::EV_RECORD_VER;
                            dw.value = {8'd0, b16};
                        end
                        PW'(tch_pkg::FX_REC_LEN_LO): begin
                            rl_next = b16;
                            if (PW'(b16) + PW'(5) > tl) begin
                                rej_next = 1'b1; phase_next = tch_pkg::PH_DONE;
                            end
                        end
                        PW'(tch_pkg::FX_MSG_TYPE): begin
                            if (b != tch_pkg::MSG_CLIENT_HELLO) begin
                                rej_next = 1'b1; phase_next = tch_pkg::PH_DONE;
                            end
                        end
                        PW'(tch_pkg::FX_MSG_LEN_0): hl_next = {16'd0, b};
                        PW'(tch_pkg::FX_MSG_LEN_1): hl_next = {hl_next[15:0], b};
                        PW'(tch_pkg::FX_MSG_LEN_2): begin
                            hl_next = {hl_next[15:0], b};
                            if (HW'(hl_next) + HW'(tch_pkg::HS_HEADER_BYTES)
                                > HW'(tl_next)) begin
                                rej_next = 1'b1; phase_next = tch_pkg::PH_DONE;
                            end
                        end
                        PW'(tch_pkg::FX_LEG_VER_LO): begin
                            dv = 1'b1; dw.event_kind = tch_pkg::EV_LEGACY_VER;
                            dw.value = {8'd0, b16};
                        end
                        PW'(tch_pkg::FX_SESSION): begin
                            if (PW'(b) + PW'(46) > tl) begin
                                rej_next = 1'b1; phase_next = tch_pkg::PH_DONE;
                            end else begin
                                le_next    = PW'(b) + PW'(44);
                                phase_next = tch_pkg::PH_CIPHER_LEN;
                            end
                        end
                        default: ;
                    endcase
                end
                tch_pkg::PH_CIPHER_LEN, tch_pkg::PH_EXTS_LEN: begin
                    if (off == le_next) begin
                        hb_next = b;
                    end else if (off == le_next + PW'(1)) begin
                        v = PW'(b16);
                        if (ph0 == tch_pkg::PH_CIPHER_LEN) begin
                            if (b[0] || off + PW'(2) + v > tl) begin
                                rej_next = 1'b1; phase_next = tch_pkg::PH_DONE;
                            end else begin
                                le_next    = off + PW'(1) + v;
                                phase_next = tch_pkg::PH_CIPHERS;
                            end
                        end else begin
                            lim     = off + PW'(1) + v;
                            ee_next = (tl < lim) ? tl : lim;
                            if (off + PW'(5) <= ee_next) begin
                                phase_next = tch_pkg::PH_EXT_HDR; ir_next = 16'd4;
                            end else begin
                                phase_next = tch_pkg::PH_DONE;
                            end
                        end
                    end
                end
                tch_pkg::PH_CIPHERS: begin
                    if (off < le_next) begin
                        lim = le_next - off;
                        if (!lim[0]) begin
                            hb_next = b;
                        end else begin
                            dv = 1'b1; dw.event_kind = tch_pkg::EV_CIPHER;
                            dw.value = {8'd0, b16};
                        end
                    end else begin
                        pos = off + PW'(1) + PW'(b);
                        if (pos > tl) begin
                            rej_next = 1'b1; phase_next = tch_pkg::PH_DONE;
                        end else if (pos + PW'(2) > tl) begin
                            phase_next = tch_pkg::PH_DONE;
                        end else begin
                            le_next = pos; phase_next = tch_pkg::PH_EXTS_LEN;
                        end
                    end
                end
                tch_pkg::PH_EXT_HDR: begin
                    if (ir_next == 16'd4 || ir_next == 16'd2) begin
                        hb_next = b; ir_next = ir_next - 16'd1;
                    end else if (ir_next == 16'd3) begin
                        ce_next = b16; ir_next = ir_next - 16'd1;
                    end else begin
                        pos = off + PW'(1);
                        if (pos + PW'(b16) > ee_next) begin
                            phase_next = tch_pkg::PH_DONE;
                        end else begin
                            dv = 1'b1; dw.event_kind = tch_pkg::EV_EXTENSION;
                            dw.value = {8'd0, ce_next};
                            xe_next = pos + PW'(b16);
                            if (ce_next == tch_pkg::EXT_SERVER_NAME && b16 >= 16'd5) begin
                                phase_next = tch_pkg::PH_SNI_LIST; ir_next = 16'd2;
                            end else if (ce_next == tch_pkg::EXT_ALPN && b16 >= 16'd2) begin
                                phase_next = tch_pkg::PH_ALPN_LIST; ir_next = 16'd2;
                            end else if (ce_next == tch_pkg::EXT_SUPP_VERS &&
                                         b16 >= 16'd3) begin
                                phase_next = tch_pkg::PH_SV_LIST;
                            end else if (b16 == 16'd0) begin
                                if (pos + PW'(4) <= ee_next) begin
                                    phase_next = tch_pkg::PH_EXT_HDR; ir_next = 16'd4;
                                end else begin
                                    phase_next = tch_pkg::PH_DONE;
                                end
                            end else begin
                                phase_next = tch_pkg::PH_SKIP;
                            end
                        end
                    end
                end
                tch_pkg::PH_SNI_LIST, tch_pkg::PH_ALPN_LIST: begin
                    if (ir_next == 16'd2) begin
                        hb_next = b; ir_next = 16'd1;
                    end else begin
                        pos     = off + PW'(1);
                        lim     = pos + PW'(b16);
                        le_next = (xe_next < lim) ? xe_next : lim;
                        if (ph0 == tch_pkg::PH_SNI_LIST) begin
                            if (pos + PW'(3) <= le_next) begin
                                phase_next = tch_pkg::PH_SNI_ENTRY; ir_next = 16'd3;
                            end else begin
                                phase_next = tch_pkg::PH_SKIP;
                            end
                        end else begin
                            phase_next = (pos < le_next) ? tch_pkg::PH_ALPN_LEN
                                                         : tch_pkg::PH_SKIP;
                        end
                    end
                end
                tch_pkg::PH_SNI_ENTRY: begin
                    if (ir_next == 16'd3) begin
                        nt_next = (b == 8'd0); ir_next = 16'd2;
                    end else if (ir_next == 16'd2) begin
                        hb_next = b; ir_next = 16'd1;
                    end else begin
                        pos = off + PW'(1);
                        if (pos + PW'(b16) > le_next) begin
                            phase_next = tch_pkg::PH_SKIP;
                        end else if (b16 == 16'd0) begin
                            if (nt_next || pos + PW'(3) > le_next) begin
                                phase_next = tch_pkg::PH_SKIP;
                            end else begin
                                phase_next = tch_pkg::PH_SNI_ENTRY; ir_next = 16'd3;
                            end
                        end else begin
                            ir_next = b16; phase_next = tch_pkg::PH_SNI_NAME;
                        end
                    end
                end
                tch_pkg::PH_SNI_NAME: begin
                    if (nt_next) begin
                        dv = 1'b1; dw.event_kind = tch_pkg::EV_SNI_BYTE;
                        dw.value = {16'd0, b};
                    end
                    ir_next = ir_next - 16'd1;
                    if (ir_next == 16'd0) begin
                        pos = off + PW'(1);
                        if (nt_next || pos + PW'(3) > le_next) begin
                            phase_next = tch_pkg::PH_SKIP;
                        end else begin
                            phase_next = tch_pkg::PH_SNI_ENTRY; ir_next = 16'd3;
                        end
                    end
                end
                tch_pkg::PH_ALPN_LEN: begin
                    pos = off + PW'(1);
                    if (pos + PW'(b) > le_next) begin
                        phase_next = tch_pkg::PH_SKIP;
                    end else begin
                        dv = 1'b1; dw.event_kind = tch_pkg::EV_ALPN_START;
                        dw.value = {16'd0, b};
                        if (b == 8'd0) begin
                            phase_next = (pos < le_next) ? tch_pkg::PH_ALPN_LEN
                                                         : tch_pkg::PH_SKIP;
                        end else begin
                            ir_next = {8'd0, b}; phase_next = tch_pkg::PH_ALPN_NAME;
                        end
                    end
                end
                tch_pkg::PH_ALPN_NAME: begin
                    dv = 1'b1; dw.event_kind = tch_pkg::EV_ALPN_BYTE;
                    dw.value = {16'd0, b};
                    ir_next = ir_next - 16'd1;
                    if (ir_next == 16'd0) begin
                        phase_next = (off + PW'(1) < le_next) ? tch_pkg::PH_ALPN_LEN
                                                             : tch_pkg::PH_SKIP;
                    end
                end
                tch_pkg::PH_SV_LIST: begin
                    pos     = off + PW'(1);
                    lim     = pos + PW'(b);
                    le_next = (xe_next < lim) ? xe_next : lim;
                    if (pos + PW'(2) <= le_next) begin
                        phase_next = tch_pkg::PH_SV_PAIR; ir_next = 16'd2;
                    end else begin
                        phase_next = tch_pkg::PH_SKIP;
                    end
                end
                tch_pkg::PH_SV_PAIR: begin
                    if (ir_next == 16'd2) begin
                        hb_next = b; ir_next = 16'd1;
                    end else begin
                        dv = 1'b1; dw.event_kind = tch_pkg::EV_SUPP_VER;
                        dw.value = {8'd0, b16};
                        if (off + PW'(3) <= le_next) begin
                            phase_next = tch_pkg::PH_SV_PAIR; ir_next = 16'd2;
                        end else begin
                            phase_next = tch_pkg::PH_SKIP;
                        end
                    end
                end
                default: ;
            endcase

            // end of the current extension body
            if (body && off + PW'(1) == xe_next) begin
                if (xe_next + PW'(4) <= ee_next) begin
                    phase_next = tch_pkg::PH_EXT_HDR; ir_next = 16'd4;
                end else begin
                    phase_next = tch_pkg::PH_DONE;
                end
            end

            if (off + PW'(1) >= tl) begin
                fw.last_of_message = 1'b1;
                if (rej_next) begin
                    fw.event_kind = tch_pkg::EV_REJECT;
                end else begin
                    fw.event_kind   = tch_pkg::EV_ACCEPT;
                    fw.value        = hl_next;
                    fw.record_bytes = 17'(rl_next) + 17'd5;
                end
                phase_next = tch_pkg::PH_IDLE;
                if (dv) begin
                    push.v0 = 1'b1; push.w0 = dw; push.v1 = 1'b1; push.w1 = fw;
                end else begin
                    push.v0 = 1'b1; push.w0 = fw;
                end
            end else if (dv) begin
                push.v0 = 1'b1; push.w0 = dw;
            end
            off_next = off_next + LENGTH_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tch_pkg::PH_IDLE;
            off_reg   <= '0;
            tl_reg    <= '0;
            rl_reg    <= '0;
            hl_reg    <= '0;
            ee_reg    <= '0;
            xe_reg    <= '0;
            le_reg    <= '0;
            ir_reg    <= '0;
            ce_reg    <= '0;
            hb_reg    <= '0;
            rej_reg   <= 1'b0;
            nt_reg    <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            off_reg   <= off_next;
            tl_reg    <= tl_next;
            rl_reg    <= rl_next;
            hl_reg    <= hl_next;
            ee_reg    <= ee_next;
            xe_reg    <= xe_next;
            le_reg    <= le_next;
            ir_reg    <= ir_next;
            ce_reg    <= ce_next;
            hb_reg    <= hb_next;
            rej_reg   <= rej_next;
            nt_reg    <= nt_next;
        end
    end

endmodule

### hw/rtl/tls_client_hello_parser.sv
// top level of the tls client hello parser
//
//  channel  direction  word                  accepted when
//  s_       in         tch_pkg::in_word_t    s_valid && s_ready
//  m_       out        tch_pkg::out_word_t   m_valid && m_ready
//
// one input word per cycle while s_ready is high; each word is parsed in the cycle it is accepted
// and its events (none, one, or an event plus the final accept or reject)
// enter a four-word result queue and are registered there before they are offered on m_
// s_ready drops while fewer than two queue slots are free
// aresetn is synchronous and active low and empties the queue
module tls_client_hello_parser #(
    parameter int LENGTH_BITS = tch_pkg::DEF_LENGTH_BITS,
    parameter int QUEUE_DEPTH = tch_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tch_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output tch_pkg::out_word_t m_word
);
    tch_pkg::push_t push;
    logic           accept;

    assign accept = s_valid & s_ready;

    tch_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .accept (accept),
        .word   (s_word),
        .push   (push)
    );

    tch_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .room   (s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_word (m_word)
    );

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push.v1 |-> push.v0 && push.w1.last_of_message && !push.w0.last_of_message)
        else $error("second pushed word is not the closing event");

    a_push_only_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        push.v0 |-> accept)
        else $error("event pushed without an accepted word");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_word.event_kind <= tch_pkg::EV_REJECT)
        else $error("result with an unknown event kind");

endmodule

### verif/tls_client_hello_parser_tb.sv
// testbench of the tls client hello parser: random hellos, self-checking event stream
module tls_client_hello_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    tch_pkg::in_word_t  s_word = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    tch_pkg::out_word_t m_word;

    tls_client_hello_parser DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_word(s_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_word(m_word)
    );

    always #1 aclk = ~aclk;

    tch_pkg::in_word_t  byte_words[$];
    tch_pkg::out_word_t event_queue[$];
    int        send_idle = 0;
    int        recv_stall = 0;
    int        errors = 0;
    int        cycles = 0;
    int        phase_start = 0;
    localparam int CYCLE_LIMIT = 300000;

    // kinds of damage done to a generated hello
    localparam int FLAW_NONE        = 0;
    localparam int FLAW_REC_TYPE    = 1;
    localparam int FLAW_MSG_TYPE    = 2;
    localparam int FLAW_ODD_CIPHERS = 3;
    localparam int FLAW_RANDOM_BYTE = 4;
    localparam int FLAW_LENGTH_OFF  = 5;
    localparam int FLAW_SHORT_EXTS  = 6;

    // parser image
    tch_pkg::phase_t ph;
    int unsigned boff, tlen, rlen, hlen, xend, eend, lend, irem, cext, hb;
    bit          rej, ntake;

    function automatic void clear_parser();
        ph = tch_pkg::PH_IDLE;
        boff = 0; tlen = 0; rlen = 0; hlen = 0; xend = 0; eend = 0;
        lend = 0; irem = 0; cext = 0; hb = 0; rej = 0; ntake = 0;
    endfunction

    function automatic void add_event(logic [3:0] kind, int unsigned val,
                                      int unsigned rb, bit last);
        tch_pkg::out_word_t e;
        e.event_kind = kind;
        e.value = val[23:0];
        e.record_bytes = rb[16:0];
        e.last_of_message = last;
        event_queue.push_back(e);
    endfunction

    function automatic void fail_parse();
        rej = 1;
        ph = tch_pkg::PH_DONE;
    endfunction

    function automatic void next_ext_header(int unsigned pos);
        if (pos + 4 <= xend) begin
            ph = tch_pkg::PH_EXT_HDR;
            irem = 4;
        end else begin
            ph = tch_pkg::PH_DONE;
        end
    endfunction

    function automatic void next_sni_entry(int unsigned pos);
        if (pos + 3 <= lend) begin
            ph = tch_pkg::PH_SNI_ENTRY;
            irem = 3;
        end else begin
            ph = tch_pkg::PH_SKIP;
        end
    endfunction

    function automatic void next_alpn(int unsigned pos);
        ph = (pos < lend) ? tch_pkg::PH_ALPN_LEN : tch_pkg::PH_SKIP;
    endfunction

    function automatic void next_sv_pair(int unsigned pos);
        if (pos + 2 <= lend) begin
            ph = tch_pkg::PH_SV_PAIR;
            irem = 2;
        end else begin
            ph = tch_pkg::PH_SKIP;
        end
    endfunction

    function automatic void parse_word(tch_pkg::in_word_t w);
        int unsigned b, off, v, pos, len;
        bit body;
        b = w.data_byte;
        if (w.start_of_message) begin
            clear_parser();
            ph = tch_pkg::PH_FIXED;
            tlen = w.message_length;
        end
        if (ph == tch_pkg::PH_IDLE) return;
        off = boff;
        body = (ph >= tch_pkg::PH_SNI_LIST) && (ph <= tch_pkg::PH_SKIP);
        case (ph)
            tch_pkg::PH_FIXED: begin
                case (off)
                    tch_pkg::FX_REC_TYPE:
                        if (b != tch_pkg::RECORD_HANDSHAKE ||
                            tlen < tch_pkg::MIN_HELLO_BYTES) fail_parse();
                    tch_pkg::FX_REC_VER_HI, tch_pkg::FX_REC_LEN_HI,
                    tch_pkg::FX_LEG_VER_HI: hb = b;
                    tch_pkg::FX_REC_VER_LO:
                        add_event(tch_pkg::EV_RECORD_VER, (hb << 8) | b, 0, 0);
                    tch_pkg::FX_REC_LEN_LO: begin
                        rlen = (hb << 8) | b;
                        if (rlen + 5 > tlen) fail_parse();
                    end
                    tch_pkg::FX_MSG_TYPE: if (b != tch_pkg::MSG_CLIENT_HELLO) fail_parse();
                    tch_pkg::FX_MSG_LEN_0: hlen = b;
                    tch_pkg::FX_MSG_LEN_1: hlen = (hlen << 8) | b;
                    tch_pkg::FX_MSG_LEN_2: begin
                        hlen = ((hlen << 8) | b) & 24'hFFFFFF;
                        if (hlen + tch_pkg::HS_HEADER_BYTES > tlen) fail_parse();
                    end
                    tch_pkg::FX_LEG_VER_LO:
                        add_event(tch_pkg::EV_LEGACY_VER, (hb << 8) | b, 0, 0);
                    tch_pkg::FX_SESSION: begin
                        if (46 + b > tlen) fail_parse();
                        else begin
                            lend = 44 + b;
                            ph = tch_pkg::PH_CIPHER_LEN;
                        end
                    end
                    default: ;
                endcase
            end
            tch_pkg::PH_CIPHER_LEN, tch_pkg::PH_EXTS_LEN: begin
                if (off == lend) hb = b;
                else if (off == lend + 1) begin
                    v = (hb << 8) | b;
                    if (ph == tch_pkg::PH_CIPHER_LEN) begin
                        if (v[0] || off + 2 + v > tlen) fail_parse();
                        else begin
                            lend = off + 1 + v;
                            ph = tch_pkg::PH_CIPHERS;
                        end
                    end else begin
                        xend = (off + 1 + v < tlen) ? off + 1 + v : tlen;
                        next_ext_header(off + 1);
                    end
                end
            end
            tch_pkg::PH_CIPHERS: begin
                if (off < lend) begin
                    if (((lend - off) & 1) == 0) hb = b;
                    else add_event(tch_pkg::EV_CIPHER, (hb << 8) | b, 0, 0);
                end else begin
                    pos = off + 1 + b;
                    if (pos > tlen) fail_parse();
                    else if (pos + 2 > tlen) ph = tch_pkg::PH_DONE;
                    else begin
                        lend = pos;
                        ph = tch_pkg::PH_EXTS_LEN;
                    end
                end
            end
            tch_pkg::PH_EXT_HDR: begin
                if (irem == 4 || irem == 2) begin
                    hb = b;
                    irem--;
                end else if (irem == 3) begin
                    cext = (hb << 8) | b;
                    irem--;
                end else begin
                    len = (hb << 8) | b;
                    pos = off + 1;
                    if (pos + len > xend) ph = tch_pkg::PH_DONE;
                    else begin
                        add_event(tch_pkg::EV_EXTENSION, cext, 0, 0);
                        eend = pos + len;
                        if (cext == tch_pkg::EXT_SERVER_NAME && len >= 5) begin
                            ph = tch_pkg::PH_SNI_LIST;
                            irem = 2;
                        end else if (cext == tch_pkg::EXT_ALPN && len >= 2) begin
                            ph = tch_pkg::PH_ALPN_LIST;
                            irem = 2;
                        end else if (cext == tch_pkg::EXT_SUPP_VERS && len >= 3) begin
                            ph = tch_pkg::PH_SV_LIST;
                        end else if (len == 0) begin
                            next_ext_header(pos);
                        end else begin
                            ph = tch_pkg::PH_SKIP;
                        end
                    end
                end
            end
            tch_pkg::PH_SNI_LIST, tch_pkg::PH_ALPN_LIST: begin
                if (irem == 2) begin
                    hb = b;
                    irem = 1;
                end else begin
                    v = off + 1 + ((hb << 8) | b);
                    lend = (eend < v) ? eend : v;
                    if (ph == tch_pkg::PH_SNI_LIST) next_sni_entry(off + 1);
                    else next_alpn(off + 1);
                end
            end
            tch_pkg::PH_SNI_ENTRY: begin
                if (irem == 3) begin
                    ntake = (b == 0);
                    irem = 2;
                end else if (irem == 2) begin
                    hb = b;
                    irem = 1;
                end else begin
                    v = (hb << 8) | b;
                    pos = off + 1;
                    if (pos + v > lend) ph = tch_pkg::PH_SKIP;
                    else if (v == 0) begin
                        if (ntake) ph = tch_pkg::PH_SKIP;
                        else next_sni_entry(pos);
                    end else begin
                        irem = v;
                        ph = tch_pkg::PH_SNI_NAME;
                    end
                end
            end
            tch_pkg::PH_SNI_NAME: begin
                if (ntake) add_event(tch_pkg::EV_SNI_BYTE, b, 0, 0);
                irem--;
                if (irem == 0) begin
                    if (ntake) ph = tch_pkg::PH_SKIP;
                    else next_sni_entry(off + 1);
                end
            end
            tch_pkg::PH_ALPN_LEN: begin
                pos = off + 1;
                if (pos + b > lend) ph = tch_pkg::PH_SKIP;
                else begin
                    add_event(tch_pkg::EV_ALPN_START, b, 0, 0);
                    if (b == 0) next_alpn(pos);
                    else begin
                        irem = b;
                        ph = tch_pkg::PH_ALPN_NAME;
                    end
                end
            end
            tch_pkg::PH_ALPN_NAME: begin
                add_event(tch_pkg::EV_ALPN_BYTE, b, 0, 0);
                irem--;
                if (irem == 0) next_alpn(off + 1);
            end
            tch_pkg::PH_SV_LIST: begin
                v = off + 1 + b;
                lend = (eend < v) ? eend : v;
                next_sv_pair(off + 1);
            end
            tch_pkg::PH_SV_PAIR: begin
                if (irem == 2) begin
                    hb = b;
                    irem = 1;
                end else begin
                    add_event(tch_pkg::EV_SUPP_VER, (hb << 8) | b, 0, 0);
                    next_sv_pair(off + 1);
                end
            end
            default: ;
        endcase
        if (body && off + 1 == eend) next_ext_header(eend);
        if (off + 1 >= tlen) begin
            if (rej) add_event(tch_pkg::EV_REJECT, 0, 0, 1);
            else add_event(tch_pkg::EV_ACCEPT, hlen, rlen + 5, 1);
            ph = tch_pkg::PH_IDLE;
        end
        boff = (off + 1) & 16'hFFFF;
    endfunction

    // stimulus building
    function automatic void push_byte(bit som, logic [7:0] d, logic [15:0] mlen);
        tch_pkg::in_word_t w;
        w.start_of_message = som;
        w.data_byte = d;
        w.message_length = som ? mlen : 16'($urandom);
        byte_words.push_back(w);
    endfunction

    function automatic void push_stray(int n);
        repeat (n) push_byte(1'b0, 8'($urandom), 16'd0);
    endfunction

    function automatic void add_ext(ref logic [7:0] ex[$], input logic [15:0] kind,
                                    input logic [7:0] bd[$]);
        ex.push_back(kind[15:8]);
        ex.push_back(kind[7:0]);
        ex.push_back(8'(bd.size() >> 8));
        ex.push_back(8'(bd.size()));
        foreach (bd[i]) ex.push_back(bd[i]);
    endfunction

    function automatic void add_hello(int flaw);
        logic [7:0] m[$];
        logic [7:0] ex[$];
        logic [7:0] bd[$];
        logic [7:0] lst[$];
        int n, k, mlen;
        repeat ($urandom_range(0, 4)) begin
            bd.delete();
            lst.delete();
            case ($urandom_range(0, 3))
                0: begin
                    repeat ($urandom_range(1, 2)) begin
                        n = $urandom_range(0, 6);
                        lst.push_back(($urandom_range(0, 3) == 0) ? 8'd1 : 8'd0);
                        lst.push_back(8'd0);
                        lst.push_back(8'(n));
                        repeat (n) lst.push_back(8'($urandom_range(8'h61, 8'h7a)));
                    end
                    bd.push_back(8'(lst.size() >> 8));
                    bd.push_back(8'(lst.size()));
                    foreach (lst[i]) bd.push_back(lst[i]);
                    add_ext(ex, tch_pkg::EXT_SERVER_NAME, bd);
                end
                1: begin
                    repeat ($urandom_range(1, 3)) begin
                        n = $urandom_range(0, 5);
                        lst.push_back(8'(n));
                        repeat (n) lst.push_back(8'($urandom));
                    end
                    bd.push_back(8'(lst.size() >> 8));
                    bd.push_back(8'(lst.size()));
                    foreach (lst[i]) bd.push_back(lst[i]);
                    add_ext(ex, tch_pkg::EXT_ALPN, bd);
                end
                2: begin
                    n = $urandom_range(1, 3);
                    bd.push_back(8'(2 * n));
                    repeat (2 * n) bd.push_back(8'($urandom));
                    add_ext(ex, tch_pkg::EXT_SUPP_VERS, bd);
                end
                default: begin
                    repeat ($urandom_range(0, 4)) bd.push_back(8'($urandom));
                    add_ext(ex, 16'($urandom), bd);
                end
            endcase
        end
        m.push_back(tch_pkg::RECORD_HANDSHAKE);
        m.push_back(8'h03);
        m.push_back(8'($urandom));
        m.push_back(8'h00);
        m.push_back(8'h00);
        m.push_back(tch_pkg::MSG_CLIENT_HELLO);
        repeat (3) m.push_back(8'h00);
        m.push_back(8'($urandom));
        m.push_back(8'($urandom));
        repeat (32) m.push_back(8'($urandom));
        n = $urandom_range(0, 4);
        m.push_back(8'(n));
        repeat (n) m.push_back(8'($urandom));
        k = 2 * $urandom_range(1, 4) + ((flaw == FLAW_ODD_CIPHERS) ? 1 : 0);
        m.push_back(8'(k >> 8));
        m.push_back(8'(k));
        repeat (k) m.push_back(8'($urandom));
        n = $urandom_range(1, 2);
        m.push_back(8'(n));
        repeat (n) m.push_back(8'($urandom));
        if ($urandom_range(0, 7) != 0) begin
            m.push_back(8'(ex.size() >> 8));
            m.push_back(8'(ex.size()));
            foreach (ex[i]) m.push_back(ex[i]);
        end else begin
            repeat ($urandom_range(0, 1)) m.push_back(8'($urandom));
        end
        m[3] = 8'((m.size() - 5) >> 8);
        m[4] = 8'(m.size() - 5);
        m[7] = 8'((m.size() - 9) >> 8);
        m[8] = 8'(m.size() - 9);
        mlen = m.size();
        case (flaw)
            FLAW_REC_TYPE:    m[0] = 8'h17;
            FLAW_MSG_TYPE:    m[5] = 8'h02;
            FLAW_RANDOM_BYTE: m[$urandom_range(0, m.size() - 1)] = 8'($urandom);
            FLAW_LENGTH_OFF:  mlen = mlen + $urandom_range(0, 6) - 3;
            FLAW_SHORT_EXTS:  mlen = mlen - $urandom_range(1, 6);
            default: ;
        endcase
        while (m.size() < mlen) m.push_back(8'($urandom));
        foreach (m[i]) push_byte(i == 0, m[i], 16'(mlen));
    endfunction

    // source
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) parse_word(s_word);
            if (!s_valid || s_ready) begin
                if (byte_words.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    s_valid <= 1'b1;
                    s_word <= byte_words.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // sink and checker
    always @(posedge aclk) begin
        if (aresetn) begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall);
            if (m_valid && m_ready) begin
                if (event_queue.size() == 0) begin
                    $display("%0t: unexpected word %p", $time, m_word);
                    errors++;
                end else begin
                    if (m_word.event_kind !== event_queue[0].event_kind ||
                        m_word.value !== event_queue[0].value ||
                        m_word.record_bytes !== event_queue[0].record_bytes ||
                        m_word.last_of_message !== event_queue[0].last_of_message) begin
                        $display("%0t: expected %p got %p", $time, event_queue[0], m_word);
                        errors++;
                    end
                    void'(event_queue.pop_front());
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        clear_parser();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed
        push_stray(3);
        push_byte(1'b1, tch_pkg::RECORD_HANDSHAKE, 16'hFFFF);
        push_stray(5);
        add_hello(FLAW_NONE);
        push_byte(1'b1, 8'($urandom), 16'd0);
        push_byte(1'b1, tch_pkg::RECORD_HANDSHAKE, 16'd1);
        push_byte(1'b1, tch_pkg::RECORD_HANDSHAKE, 16'd43);
        push_stray(2);
        for (int f = FLAW_REC_TYPE; f <= FLAW_SHORT_EXTS; f++) add_hello(f);
        push_stray(2);

        for (int p = 0; p < 4; p++) begin
            send_idle  = (p == 1 || p == 3) ? ((p == 1) ? 66 : 23) : 0;
            recv_stall = (p == 2 || p == 3) ? ((p == 2) ? 66 : 23) : 0;
            phase_start = byte_words.size();
            while (byte_words.size() < phase_start + 140) begin
                if ($urandom_range(0, 9) < 7) add_hello(FLAW_NONE);
                else add_hello($urandom_range(FLAW_REC_TYPE, FLAW_SHORT_EXTS));
                if ($urandom_range(0, 9) == 0) push_stray($urandom_range(1, 3));
            end
            while (byte_words.size() != 0 || s_valid) @(posedge aclk);
        end

        while (event_queue.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0 && event_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### tls_client_hello_parser.f
hw/rtl/tch_pkg.sv
hw/rtl/tch_queue.sv
hw/rtl/tch_core.sv
hw/rtl/tls_client_hello_parser.sv
verif/tls_client_hello_parser_tb.sv
